// ===== hdl/htpwm_pkg.sv =====
// Shared types and constants of the heater time-proportioning PWM core.
package htpwm_pkg;

  // Default width of the phase tick counter.
  localparam int COUNT_WIDTH_DEF = 16;

  // Duty percent at and above which the output is held fully on.
  localparam logic [7:0] PCT_FULL = 8'd100;

  // Reset value of the PWM period in ticks.
  localparam logic [15:0] CYCLE_RESET = 16'd1000;

  // Widths of the scaled on time product (duty 1..99 times a 16-bit period).
  localparam int PROD_W = 23;

  // Reciprocal of 100 for products below 2**23: on = (prod * RECIP_MUL) >> RECIP_SHIFT.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd10737419;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CYCLE_LENGTH = 3'd0,
    REG_INVERT       = 3'd1,
    REG_SET_POINT    = 3'd2,
    REG_OFFSET_BIG   = 3'd3,
    REG_OFFSET_SMALL = 3'd4,
    REG_BAND_DUTIES  = 3'd5
  } cfg_reg_e;

  // Kind of drive that one tick asks for.
  typedef enum logic [1:0] {
    CLS_OFF = 2'd0,
    CLS_ON  = 2'd1,
    CLS_PWM = 2'd2
  } duty_cls_e;

  // Current configuration, as seen by the duty and scale stages.
  typedef struct packed {
    logic [15:0]        cycle_length;
    logic               invert;
    logic signed [15:0] set_point;
    logic [14:0]        offset_big;
    logic [14:0]        offset_small;
    logic [31:0]        band_duties;
  } cfg_t;

  // Item after band selection and period multiply.
  typedef struct packed {
    duty_cls_e         cls;
    logic [PROD_W-1:0] prod;
  } prod_item_t;

  // Item with its on and off times worked out.
  typedef struct packed {
    duty_cls_e   cls;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } time_item_t;

endpackage

// ===== hdl/htpwm_cfg.sv =====
// Configuration register file of the heater PWM core.
module htpwm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  output htpwm_pkg::cfg_t     cfg_o
);

  htpwm_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (htpwm_pkg::cfg_reg_e'(cfg_idx_i))
        htpwm_pkg::REG_CYCLE_LENGTH: cfg_d.cycle_length = cfg_wdata_i[15:0];
        htpwm_pkg::REG_INVERT:       cfg_d.invert       = cfg_wdata_i[0];
        htpwm_pkg::REG_SET_POINT:    cfg_d.set_point    = $signed(cfg_wdata_i[15:0]);
        htpwm_pkg::REG_OFFSET_BIG:   cfg_d.offset_big   = cfg_wdata_i[14:0];
        htpwm_pkg::REG_OFFSET_SMALL: cfg_d.offset_small = cfg_wdata_i[14:0];
        htpwm_pkg::REG_BAND_DUTIES:  cfg_d.band_duties  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cycle_length: htpwm_pkg::CYCLE_RESET,
                 invert:       1'b0,
                 set_point:    16'sd0,
                 offset_big:   15'd0,
                 offset_small: 15'd0,
                 band_duties:  32'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/htpwm_duty.sv =====
// Input register, band selection and period multiply of the heater PWM core.
module htpwm_duty (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  htpwm_pkg::cfg_t         cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    func_i,
  input  logic [7:0]              duty_percent_i,
  input  logic signed [15:0]      temperature_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output htpwm_pkg::prod_item_t   out_item_o
);

  logic                   in_v_q;
  logic                   func_q;
  logic [7:0]             duty_q;
  logic signed [15:0]     temp_q;
  logic                   out_v_q;
  htpwm_pkg::prod_item_t  item_q, item_d;
  logic                   stage_ready;

  logic signed [16:0]     temp_x;
  logic signed [16:0]     edge_small;
  logic signed [16:0]     edge_big;
  logic signed [16:0]     set_x;
  logic [1:0]             band_sel;
  logic [7:0]             duty;

  assign stage_ready = !out_v_q || out_ready_i;
  assign in_ready_o  = !in_v_q || stage_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      duty_q <= duty_percent_i;
      temp_q <= temperature_i;
    end
  end

  // Band edges, widened so they cannot wrap; later band tests win.
  always_comb begin
    temp_x     = $signed({temp_q[15], temp_q});
    set_x      = $signed({cfg_i.set_point[15], cfg_i.set_point});
    edge_small = set_x - $signed({2'b00, cfg_i.offset_small});
    edge_big   = set_x - $signed({2'b00, cfg_i.offset_big});
    band_sel   = 2'd0;
    if (temp_x < edge_small && temp_x >= edge_big) band_sel = 2'd1;
    if (temp_x >= edge_small && temp_x < set_x)    band_sel = 2'd2;
    if (temp_x >= set_x)                           band_sel = 2'd3;
    duty = func_q ? cfg_i.band_duties[8*band_sel +: 8] : duty_q;
  end

  // Classify the duty and scale it by the period; only duties below 100 use the product.
  always_comb begin
    if (duty >= htpwm_pkg::PCT_FULL) begin
      item_d.cls = htpwm_pkg::CLS_ON;
    end else if (duty == 8'd0) begin
      item_d.cls = htpwm_pkg::CLS_OFF;
    end else begin
      item_d.cls = htpwm_pkg::CLS_PWM;
    end
    item_d.prod = htpwm_pkg::PROD_W'(duty[6:0]) * htpwm_pkg::PROD_W'(cfg_i.cycle_length);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (stage_ready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q && stage_ready) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = item_q;

endmodule

// ===== hdl/htpwm_scale.sv =====
// Divide-by-100 stage that turns the scaled duty into on and off times.
module htpwm_scale (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  htpwm_pkg::cfg_t         cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  htpwm_pkg::prod_item_t   in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output htpwm_pkg::time_item_t   out_item_o
);

  localparam int WideW = htpwm_pkg::PROD_W + htpwm_pkg::RECIP_W;

  logic                   out_v_q;
  htpwm_pkg::time_item_t  item_q, item_d;
  logic [WideW-1:0]       wide;

  assign in_ready_o = !out_v_q || out_ready_i;

  // Reciprocal multiply gives floor(prod / 100) exactly over the product range.
  always_comb begin
    wide             = WideW'(in_item_i.prod) * WideW'(htpwm_pkg::RECIP_MUL);
    item_d.cls       = in_item_i.cls;
    item_d.on_ticks  = wide[htpwm_pkg::RECIP_SHIFT +: 16];
    item_d.off_ticks = cfg_i.cycle_length - item_d.on_ticks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_ready_o) begin
      out_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = item_q;

endmodule

// ===== hdl/htpwm_phase.sv =====
// Phase timer, pin state and result register of the heater PWM core.
module htpwm_phase #(
  parameter int CountWidth = htpwm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    invert_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  htpwm_pkg::time_item_t   in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    drive_level_o
);

  localparam int CmpW = (CountWidth > 16) ? CountWidth : 16;

  logic                  out_v_q;
  logic [CountWidth-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                  on_phase_q, on_phase_d;
  logic                  pin_q, pin_d;
  logic                  load;

  assign in_ready_o = !out_v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Saturating tick count.
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + CountWidth'(1);

  // One tick of the slow PWM; an on edge and an off edge may both fall in one tick.
  always_comb begin
    elapsed_d  = elapsed_q;
    on_phase_d = on_phase_q;
    pin_d      = pin_q;
    if (load) begin
      elapsed_d = elapsed_inc;
      case (in_item_i.cls)
        htpwm_pkg::CLS_ON:  pin_d = ~invert_i;
        htpwm_pkg::CLS_OFF: pin_d = invert_i;
        htpwm_pkg::CLS_PWM: begin
          if (!on_phase_d && CmpW'(elapsed_d) >= CmpW'(in_item_i.off_ticks)) begin
            elapsed_d  = '0;
            pin_d      = ~invert_i;
            on_phase_d = 1'b1;
          end
          if (on_phase_d && CmpW'(elapsed_d) >= CmpW'(in_item_i.on_ticks)) begin
            elapsed_d  = '0;
            pin_d      = invert_i;
            on_phase_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      elapsed_q  <= '0;
      on_phase_q <= 1'b0;
      pin_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        out_v_q <= in_valid_i;
      end
      elapsed_q  <= elapsed_d;
      on_phase_q <= on_phase_d;
      pin_q      <= pin_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign drive_level_o = pin_q;

  // Timer and pin state move only when an item is taken.
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(load) |-> ($stable(elapsed_q) && $stable(on_phase_q) && $stable(pin_q)))
    else $error("phase state changed without an item");

  // Every phase change restarts the tick count.
  a_phase_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(on_phase_q) |-> (elapsed_q == '0))
    else $error("phase changed but tick count not cleared");

  // A full-on item drives the active level.
  a_full_on_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_item_i.cls == htpwm_pkg::CLS_ON) |=> (pin_q == !$past(invert_i)))
    else $error("full-on item did not drive the active level");

endmodule

// ===== hdl/heater_time_proportioning_pwm_core.sv =====
// Top level of the heater time-proportioning slow PWM core.
//
// Each input item is one time tick on the slave stream. tuser carries func
// (0: tdata duty percent is used, 1: the temperature picks one of four band
// duties). A duty of 100 or more holds the drive on, 0 holds it off, and any
// other duty runs a slow PWM of cycle_length ticks with floor(duty*cycle/100)
// on ticks. Each tick gives one item on the master stream: the drive level.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
// stream is idle.
// The path from acceptance to the result being valid runs through the input
// register, band select and period multiply, reciprocal divide by 100, then
// the phase timer update that loads the result register. One item per cycle
// is sustained while the receiver is ready; the phase timer is the only loop.
// When the receiver stalls, finished items wait in their stage registers and
// the input keeps being taken until every stage is full.
// Reset clears the stages, the phase timer, the pin level and the registers
// (period back to 1000 ticks).
module heater_time_proportioning_pwm_core #(
  parameter int CountWidth = htpwm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Tick stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] duty_percent, [23:8] temperature
  input  logic [0:0]  s_axis_tuser,   // [0] func
  // Drive level stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] drive_level, rest zero
);

  htpwm_pkg::cfg_t       cfg;
  logic                  p1_valid, p1_ready;
  htpwm_pkg::prod_item_t p1_item;
  logic                  p2_valid, p2_ready;
  htpwm_pkg::time_item_t p2_item;
  logic                  drive_level;

  htpwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  htpwm_duty u_duty (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .func_i         (s_axis_tuser[0]),
    .duty_percent_i (s_axis_tdata[7:0]),
    .temperature_i  ($signed(s_axis_tdata[23:8])),
    .out_valid_o    (p1_valid),
    .out_ready_i    (p1_ready),
    .out_item_o     (p1_item)
  );

  htpwm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (p1_valid),
    .in_ready_o  (p1_ready),
    .in_item_i   (p1_item),
    .out_valid_o (p2_valid),
    .out_ready_i (p2_ready),
    .out_item_o  (p2_item)
  );

  htpwm_phase #(
    .CountWidth (CountWidth)
  ) u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .invert_i      (cfg.invert),
    .in_valid_i    (p2_valid),
    .in_ready_o    (p2_ready),
    .in_item_i     (p2_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .drive_level_o (drive_level)
  );

  assign m_axis_tdata = {7'b0, drive_level};

endmodule

// ===== bench/heater_time_proportioning_pwm_core_test.sv =====
// Self-checking testbench of the heater time-proportioning PWM core.
`timescale 1ns / 100ps

module heater_time_proportioning_pwm_core_test;

  localparam int CountW = htpwm_pkg::COUNT_WIDTH_DEF;
  localparam int unsigned PctScale = 100;
  localparam int TotalTicks = 850;
  localparam int LongHold = 120;
  localparam int StuckLimit = 2000;
  localparam int SettleCycles = 8;

  // One tick item as offered on the input stream.
  typedef struct {
    logic               regulate;
    logic [7:0]         pct;
    logic signed [15:0] temp;
  } tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = htpwm_pkg::REG_CYCLE_LENGTH;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] duty_percent, [23:8] temperature
  logic [0:0]  s_axis_tuser = '0;  // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [0] drive_level

  heater_time_proportioning_pwm_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration registers.
  logic [15:0]        cyc_len = htpwm_pkg::CYCLE_RESET;
  logic               inv = 1'b0;
  logic signed [15:0] setpt = '0;
  logic [14:0]        ofs_big = '0;
  logic [14:0]        ofs_small = '0;
  logic [31:0]        band_pct = '0;

  // Shadow copy of the phase timer and the pin.
  logic [CountW-1:0] tick_count = '0;
  logic              in_on_phase = 1'b0;
  logic              pin_state = 1'b0;

  tick_t tick_queue[$];
  logic  expected_levels[$];
  tick_t cur_tick;

  int ticks_issued = 0;
  int ticks_accepted = 0;
  int results_seen = 0;
  int level_mismatches = 0;
  int stray_results = 0;
  int reports = 0;
  int full_on_ticks = 0;
  int full_off_ticks = 0;
  int pwm_ticks = 0;
  int cfg_writes = 0;
  int phases = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int stuck = 0;
  bit long_hold_done = 1'b0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit quiet_tail = 1'b0;

  // Duty that a temperature selects; later band tests override earlier ones.
  function automatic logic [7:0] band_duty(logic signed [15:0] temp);
    int t;
    int sp;
    int lo_edge;
    int mid_edge;
    int sel;
    t = temp;
    sp = setpt;
    lo_edge = sp - int'(ofs_big);
    mid_edge = sp - int'(ofs_small);
    sel = 0;
    if (t < mid_edge && t >= lo_edge) sel = 1;
    if (t >= mid_edge && t < sp) sel = 2;
    if (t >= sp) sel = 3;
    return band_pct[8*sel +: 8];
  endfunction

  // Advances the shadow timer by one tick and returns the new drive level.
  function automatic logic next_drive(tick_t it);
    logic [7:0]  pct;
    int unsigned on_t;
    int unsigned off_t;
    pct = it.regulate ? band_duty(it.temp) : it.pct;
    if (tick_count != {CountW{1'b1}}) tick_count++;
    if (pct >= htpwm_pkg::PCT_FULL) begin
      pin_state = ~inv;
      full_on_ticks++;
    end else if (pct == 8'd0) begin
      pin_state = inv;
      full_off_ticks++;
    end else begin
      on_t = (32'(pct) * 32'(cyc_len)) / PctScale;
      off_t = 32'(cyc_len) - on_t;
      if (!in_on_phase && 32'(tick_count) >= off_t) begin
        tick_count = '0;
        pin_state = ~inv;
        in_on_phase = 1'b1;
      end
      if (in_on_phase && 32'(tick_count) >= on_t) begin
        tick_count = '0;
        pin_state = inv;
        in_on_phase = 1'b0;
      end
      pwm_ticks++;
    end
    return pin_state;
  endfunction

  task automatic add_tick(logic regulate, logic [7:0] pct, logic signed [15:0] temp);
    tick_t t;
    t.regulate = regulate;
    t.pct = pct;
    t.temp = temp;
    tick_queue.push_back(t);
    ticks_issued++;
  endtask

  // Register write; the shadow copy follows at once since the core is idle.
  task automatic write_reg(htpwm_pkg::cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      htpwm_pkg::REG_CYCLE_LENGTH: cyc_len = val[15:0];
      htpwm_pkg::REG_INVERT:       inv = val[0];
      htpwm_pkg::REG_SET_POINT:    setpt = val[15:0];
      htpwm_pkg::REG_OFFSET_BIG:   ofs_big = val[14:0];
      htpwm_pkg::REG_OFFSET_SMALL: ofs_small = val[14:0];
      htpwm_pkg::REG_BAND_DUTIES:  band_pct = val;
      default: ;
    endcase
  endtask

  // Waits until every tick has produced its result, then lets the pipe settle.
  task automatic wait_idle();
    while (results_seen < ticks_issued) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Duty mix: off, exactly full, above full, any byte, and mostly PWM.
  function automatic logic [7:0] rand_pct();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return htpwm_pkg::PCT_FULL;
      2: return 8'($urandom_range(101, 255));
      3: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 99));
    endcase
  endfunction

  function automatic logic signed [15:0] near_temp(int base);
    int v;
    v = base + int'($urandom_range(0, 8)) - 4;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Temperatures cluster around the band edges, with some spread over the range.
  function automatic logic signed [15:0] band_temp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return near_temp(setpt);
      2: return near_temp(int'(setpt) - int'(ofs_small));
      3: return near_temp(int'(setpt) - int'(ofs_big));
      4: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return near_temp(int'(setpt) - int'($urandom_range(0, 400)));
    endcase
  endfunction

  // The first two shapes pin the register extremes, the rest are random.
  task automatic pick_config(int shape);
    logic [15:0]        cl;
    logic signed [15:0] sp;
    logic [14:0]        ob;
    logic [14:0]        os;
    logic [31:0]        bd;
    case (shape)
      0: begin
        cl = 16'hFFFF;
        sp = 16'sh8000;
        ob = 15'h7FFF;
        os = 15'h7FFF;
      end
      1: begin
        cl = 16'd1;
        sp = 16'sh7FFF;
        ob = '0;
        os = '0;
      end
      default: begin
        case ($urandom_range(0, 9))
          0: cl = 16'd0;
          1: cl = 16'd1;
          2: cl = 16'hFFFF;
          3: cl = 16'($urandom_range(100, 2000));
          default: cl = 16'($urandom_range(2, 40));
        endcase
        case ($urandom_range(0, 5))
          0: sp = 16'sh8000;
          1: sp = 16'sh7FFF;
          2: sp = 16'($urandom);
          default: sp = 16'(int'($urandom_range(0, 4000)) - 2000);
        endcase
        case ($urandom_range(0, 4))
          0: ob = '0;
          1: ob = 15'h7FFF;
          2: ob = 15'($urandom);
          default: ob = 15'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 4))
          0: os = '0;
          1: os = 15'h7FFF;
          2: os = 15'($urandom);
          default: os = 15'($urandom_range(0, 300));
        endcase
      end
    endcase
    bd = {rand_pct(), rand_pct(), rand_pct(), rand_pct()};
    write_reg(htpwm_pkg::REG_CYCLE_LENGTH, {16'h0, cl});
    write_reg(htpwm_pkg::REG_INVERT, {31'h0, 1'($urandom_range(0, 1))});
    write_reg(htpwm_pkg::REG_SET_POINT, {16'h0, sp});
    write_reg(htpwm_pkg::REG_OFFSET_BIG, {17'h0, ob});
    write_reg(htpwm_pkg::REG_OFFSET_SMALL, {17'h0, os});
    write_reg(htpwm_pkg::REG_BAND_DUTIES, bd);
  endtask

  // Mostly runs of one repeated tick so PWM periods complete, plus lone noise ticks.
  task automatic gen_phase(int n);
    int    cnt;
    int    len;
    tick_t t;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 6) == 0) begin
        add_tick(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
        cnt++;
      end else begin
        t.regulate = 1'($urandom_range(0, 1));
        t.pct = t.regulate ? 8'($urandom) : rand_pct();
        t.temp = t.regulate ? band_temp() : 16'($urandom);
        len = $urandom_range(1, 40);
        if (len > n - cnt) len = n - cnt;
        repeat (len) add_tick(t.regulate, t.pct, t.temp);
        cnt += len;
      end
    end
  endtask

  // Sender: offers queued items, with random gaps after accepted ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_levels.push_back(next_drive(cur_tick));
        ticks_accepted++;
        if (send_idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 12);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || tick_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_tick = tick_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_tick.temp, cur_tick.pct};
          s_axis_tuser <= cur_tick.regulate;
        end
      end
    end
  end

  // Receiver: short random stalls, and once a long hold so the core backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && !quiet_tail && results_seen >= 200 &&
                 tick_queue.size() >= 20) begin
      long_hold_done = 1'b1;
      hold_left = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checker: each drive level against the oldest predicted one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        stray_results++;
        if (reports < 10) begin
          reports++;
          $display("%0t: drive item 0x%02h with none predicted", $realtime, m_axis_tdata);
        end
      end else begin
        if (m_axis_tdata !== {7'h0, expected_levels[0]}) begin
          level_mismatches++;
          if (reports < 10) begin
            reports++;
            $display("%0t: drive item %0d expected 0x%02h, got 0x%02h", $realtime,
                     results_seen - 1, {7'h0, expected_levels[0]}, m_axis_tdata);
          end
        end
        void'(expected_levels.pop_front());
      end
    end
  end

  // Watchdog: counts cycles without progress while work is outstanding.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        results_seen >= ticks_issued) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= StuckLimit) begin
        $display("no progress for %0d cycles, %0d of %0d results seen",
                 StuckLimit, results_seen, ticks_issued);
        $display("heater_time_proportioning_pwm_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: 1000-tick period and all band duties zero.
    add_tick(1'b0, 8'd0, 16'sd0);
    add_tick(1'b0, 8'd100, 16'sd0);
    add_tick(1'b0, 8'd255, -16'sd1);
    add_tick(1'b0, 8'd1, 16'sh7FFF);
    add_tick(1'b0, 8'd99, 16'sh8000);
    add_tick(1'b0, 8'd50, 16'sh5555);
    add_tick(1'b1, 8'hAA, 16'sh8000);
    add_tick(1'b1, 8'h55, 16'sh7FFF);
    wait_idle();
    phases++;

    // Bands 0/10/50/100 percent with edges at 60, 80 and 100; every edge hit.
    write_reg(htpwm_pkg::REG_CYCLE_LENGTH, 32'd4);
    write_reg(htpwm_pkg::REG_SET_POINT, 32'd100);
    write_reg(htpwm_pkg::REG_OFFSET_BIG, 32'd40);
    write_reg(htpwm_pkg::REG_OFFSET_SMALL, 32'd20);
    write_reg(htpwm_pkg::REG_BAND_DUTIES, 32'h6432_0A00);
    add_tick(1'b1, 8'd0, 16'sh8000);
    add_tick(1'b1, 8'd0, 16'sd59);
    add_tick(1'b1, 8'd0, 16'sd60);
    add_tick(1'b1, 8'd0, 16'sd79);
    add_tick(1'b1, 8'd0, 16'sd80);
    add_tick(1'b1, 8'd0, 16'sd99);
    add_tick(1'b1, 8'd0, 16'sd100);
    add_tick(1'b1, 8'd0, 16'sh7FFF);
    // Ten percent of four ticks rounds to no on time at all.
    repeat (3) add_tick(1'b0, 8'd10, 16'sd0);
    repeat (3) add_tick(1'b0, 8'd99, 16'sd0);
    wait_idle();
    phases++;

    // Random phases, each with a fresh configuration.
    while (ticks_issued < TotalTicks) begin
      if (TotalTicks - ticks_issued <= 120) quiet_tail = 1'b1;
      send_idle_on = $urandom_range(0, 2) != 0;
      recv_idle_on = $urandom_range(0, 2) != 0;
      pick_config(phases - 2);
      gen_phase(quiet_tail ? TotalTicks - ticks_issued : $urandom_range(40, 100));
      wait_idle();
      phases++;
    end

    $display("%0d ticks in %0d configurations (%0d register writes): %0d full on, %0d full off,",
             ticks_accepted, phases, cfg_writes, full_on_ticks, full_off_ticks);
    $display("%0d PWM; %0d results checked, %0d mismatches, %0d unexpected, long hold %0s",
             pwm_ticks, results_seen, level_mismatches, stray_results,
             long_hold_done ? "done" : "not reached");
    if (level_mismatches == 0 && stray_results == 0 && expected_levels.size() == 0) begin
      $display("heater_time_proportioning_pwm_core_test passed");
    end else begin
      $display("heater_time_proportioning_pwm_core_test failed");
    end
    $finish;
  end

endmodule
